[hdl/nalkc_pkg.sv]
// Shared types and constants for the Annex B NAL keyframe classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package nalkc_pkg;

  // Item kinds carried on the input tuser field.
  // The value 3 is undefined; the block ignores it.
  typedef enum logic [1:0] {
    KIND_PKT   = 2'd0,
    KIND_XDATA = 2'd1,
    KIND_RESET = 2'd2
  } kind_t;

  // Key NAL scan window and the saturation limit of the NAL counter
  localparam logic [3:0] KEY_SCAN_NALS = 4'd8;
  localparam logic [3:0] NAL_CHK_MAX   = 4'd15;

  // Fill level of the start-code window, saturating at a full window
  localparam logic [2:0] WIN_FULL      = 3'd4;

  // NAL type codes
  localparam logic [5:0] HEVC_KEY_LO   = 6'd19;
  localparam logic [5:0] HEVC_KEY_HI   = 6'd21;
  localparam logic [5:0] HEVC_VPS      = 6'd32;
  localparam logic [5:0] HEVC_SPS      = 6'd33;
  localparam logic [5:0] HEVC_PPS      = 6'd34;
  localparam logic [5:0] AVC_IDR       = 6'd5;
  localparam logic [5:0] AVC_SPS       = 6'd7;
  localparam logic [5:0] AVC_PPS       = 6'd8;

  // Header field masks
  localparam logic [7:0] HEVC_TYPE_MASK = 8'h3F;
  localparam logic [7:0] AVC_TYPE_MASK  = 8'h1F;

  // One per-packet result, is_keyframe in bit 0
  typedef struct packed {
    logic [2:0] stored_mask;
    logic       forward;
    logic       inject_needed;
    logic       carries_param_sets;
    logic       is_keyframe;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage : nalkc_pkg

`default_nettype wire

[hdl/nalkc_scan.sv]
// Start-code scanner, NAL header decode and per-packet classification.
// Holds all stream state; depends on nalkc_pkg.
`default_nettype none

module nalkc_scan
  import nalkc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wen,
  input  wire logic       cfg_wdata,
  input  wire logic       item_acc,
  input  wire logic [1:0] item_kind,
  input  wire logic [7:0] item_byte,
  input  wire logic       item_last,
  input  wire logic       item_ckey,
  output logic            res_vld,
  output result_t         res
);

  logic        codec_hevc_r;
  logic [31:0] win_r, win_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [3:0]  nal_chk_r, nal_chk_nxt;
  logic        key_found_r, key_found_nxt;
  logic [2:0]  pend_ps_r, pend_ps_nxt;
  logic [2:0]  ps_present_r, ps_present_nxt;
  logic        seen_kf_r, seen_kf_nxt;

  logic        match;
  logic [7:0]  hdr;
  logic [5:0]  nal_type;
  logic        key_type;
  logic [2:0]  found_ps;

  // scan results before kind handling
  logic [31:0] s_win;
  logic [2:0]  s_seen;
  logic [3:0]  s_nal_chk;
  logic        s_key_found;
  logic [2:0]  s_pend;
  logic        pkt_key;
  logic        pkt_fwd;
  logic        pkt_carries;

  // Window compare and header decode
  always_comb begin
    match = (seen_r >= WIN_FULL) && (win_r[31:16] == 16'h0000) && (win_r[15:8] == 8'h01);
    hdr   = win_r[7:0];
    if (codec_hevc_r) begin
      nal_type = 6'((hdr >> 1) & HEVC_TYPE_MASK);
      key_type = (nal_type >= HEVC_KEY_LO) && (nal_type <= HEVC_KEY_HI);
      found_ps = 3'b000;
      if (nal_type == HEVC_VPS) begin
        found_ps = 3'b001;
      end else if (nal_type == HEVC_SPS) begin
        found_ps = 3'b010;
      end else if (nal_type == HEVC_PPS) begin
        found_ps = 3'b100;
      end
    end else begin
      nal_type = 6'(hdr & AVC_TYPE_MASK);
      key_type = (nal_type == AVC_IDR);
      found_ps = 3'b000;
      if (nal_type == AVC_SPS) begin
        found_ps = 3'b001;
      end else if (nal_type == AVC_PPS) begin
        found_ps = 3'b010;
      end
    end
    if (!match) begin
      found_ps = 3'b000;
    end
  end

  // Scan state update; a match restarts the window at the current byte,
  // which skips the header byte past the start code
  always_comb begin
    s_nal_chk   = nal_chk_r;
    s_key_found = key_found_r;
    if (match) begin
      if (!key_found_r && (nal_chk_r < KEY_SCAN_NALS)) begin
        if (key_type) begin
          s_key_found = 1'b1;
        end else if (nal_chk_r < NAL_CHK_MAX) begin
          s_nal_chk = nal_chk_r + 4'd1;
        end
      end
      s_win  = {24'h000000, item_byte};
      s_seen = 3'd1;
    end else begin
      s_win  = {win_r[23:0], item_byte};
      s_seen = (seen_r < WIN_FULL) ? seen_r + 3'd1 : seen_r;
    end
    s_pend      = pend_ps_r | found_ps;
    pkt_key     = item_ckey | s_key_found;
    pkt_fwd     = seen_kf_r | pkt_key;
    pkt_carries = pkt_fwd && (s_pend != 3'b000);
  end

  // Kind handling and result
  always_comb begin
    win_nxt        = win_r;
    seen_nxt       = seen_r;
    nal_chk_nxt    = nal_chk_r;
    key_found_nxt  = key_found_r;
    pend_ps_nxt    = pend_ps_r;
    ps_present_nxt = ps_present_r;
    seen_kf_nxt    = seen_kf_r;
    res_vld        = 1'b0;
    res            = '0;
    if (item_acc) begin
      case (item_kind)
        KIND_RESET: begin
          win_nxt        = '0;
          seen_nxt       = '0;
          nal_chk_nxt    = '0;
          key_found_nxt  = 1'b0;
          pend_ps_nxt    = '0;
          ps_present_nxt = '0;
          seen_kf_nxt    = 1'b0;
        end
        KIND_XDATA: begin
          ps_present_nxt = ps_present_r | found_ps;
          if (item_last) begin
            win_nxt       = '0;
            seen_nxt      = '0;
            nal_chk_nxt   = '0;
            key_found_nxt = 1'b0;
            pend_ps_nxt   = '0;
          end else begin
            win_nxt       = s_win;
            seen_nxt      = s_seen;
            nal_chk_nxt   = s_nal_chk;
            key_found_nxt = s_key_found;
          end
        end
        KIND_PKT: begin
          if (item_last) begin
            win_nxt       = '0;
            seen_nxt      = '0;
            nal_chk_nxt   = '0;
            key_found_nxt = 1'b0;
            pend_ps_nxt   = '0;
            if (pkt_fwd) begin
              ps_present_nxt = ps_present_r | s_pend;
              seen_kf_nxt    = seen_kf_r | pkt_key;
            end
            res_vld                = 1'b1;
            res.is_keyframe        = pkt_key;
            res.forward            = pkt_fwd;
            res.carries_param_sets = pkt_carries;
            res.inject_needed      = pkt_fwd && pkt_key && !pkt_carries &&
                                     (ps_present_r != 3'b000);
            res.stored_mask        = pkt_fwd ? (ps_present_r | s_pend) : ps_present_r;
          end else begin
            win_nxt       = s_win;
            seen_nxt      = s_seen;
            nal_chk_nxt   = s_nal_chk;
            key_found_nxt = s_key_found;
            pend_ps_nxt   = s_pend;
          end
        end
        default: begin
          // undefined kind: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_hevc_r <= 1'b1;
      win_r        <= '0;
      seen_r       <= '0;
      nal_chk_r    <= '0;
      key_found_r  <= 1'b0;
      pend_ps_r    <= '0;
      ps_present_r <= '0;
      seen_kf_r    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        codec_hevc_r <= cfg_wdata;
      end
      win_r        <= win_nxt;
      seen_r       <= seen_nxt;
      nal_chk_r    <= nal_chk_nxt;
      key_found_r  <= key_found_nxt;
      pend_ps_r    <= pend_ps_nxt;
      ps_present_r <= ps_present_nxt;
      seen_kf_r    <= seen_kf_nxt;
    end
  end

  // A dropped packet never reports parameter sets or injection
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !res.forward) |-> (!res.carries_param_sets && !res.inject_needed))
    else $error("dropped packet reports parameter sets or injection");

  // seen_keyframe only clears through a reset item
  a_kf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(seen_kf_r) |-> $past(item_acc && (item_kind == KIND_RESET)))
    else $error("seen_keyframe cleared without reset item");

  // Parameter-set mask only shrinks through a reset item
  a_mask_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (($past(ps_present_r) & ~ps_present_r) != 3'b000)
    |-> $past(item_acc && (item_kind == KIND_RESET)))
    else $error("parameter-set mask lost bits without reset item");

endmodule : nalkc_scan

`default_nettype wire

[hdl/nalkc_obuf.sv]
// Two-entry result buffer between the classifier and the output channel.
// Depends on nalkc_pkg for the result type.
`default_nettype none

module nalkc_obuf
  import nalkc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  result_t      push_data,
  output logic         full,
  output logic         pop_vld,
  input  wire logic    pop_rdy,
  output result_t      pop_data
);

  result_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full     = (cnt_r == 2'd2);
  assign pop_vld  = (cnt_r != 2'd0);
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into full buffer");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("buffer count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("buffer pointers disagree with count");

endmodule : nalkc_obuf

`default_nettype wire

[hdl/annexb_nal_keyframe_classifier.sv]
// Top level of the Annex B NAL keyframe classifier.
// Instantiates nalkc_scan and nalkc_obuf; depends on nalkc_pkg.
//
// Usage:
//   Input channel (in_*): one byte per item. in_tuser carries the kind
//   (packet byte, extradata byte, new-connection reset), in_tlast marks the
//   last byte of a packet or extradata block, in_tdata carries the byte and
//   the container key flag (sampled only on a packet's last byte).
//   Output channel (out_*): one result item per packet, produced by the
//   packet's last byte. Extradata, reset items and undefined kinds produce
//   no result.
//   Configuration: cfg_wen writes cfg_wdata into codec_is_hevc (1 = H.265
//   header rules, 0 = H.264). Write it only while the block is idle.
// Timing:
//   One item per clock while in_tready is high. Each byte goes through the
//   start-code window compare and header decode in the cycle it is accepted;
//   a packet's result shows on out_tvalid the cycle after its last byte is taken.
// Reset (rst_n low, synchronous): scan state, parameter-set mask and the
//   seen-keyframe flag clear, codec_is_hevc returns to H.265, the result
//   buffer empties.
// Backpressure: a two-entry result buffer separates the sides. Bytes keep
//   flowing while results wait; in_tready is low while two results are held
//   (only reachable with out_tready low) and rises the cycle after one is
//   taken.
`default_nettype none

module annexb_nal_keyframe_classifier
  import nalkc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,   // codec_is_hevc
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [7:0] data_byte, [8] container_key, rest zero
  input  wire logic [1:0]  in_tuser,    // [1:0] kind
  input  wire logic        in_tlast,    // last_byte
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata    // [0] is_keyframe, [1] carries_param_sets,
                                        // [2] inject_needed, [3] forward,
                                        // [6:4] stored_mask, [7] zero
);

  logic    acc;
  logic    res_vld;
  result_t res;
  logic    buf_full;
  result_t out_res;

  // Ready only depends on buffer fill, not on the incoming item
  assign in_tready = !buf_full;
  assign acc       = in_tvalid && in_tready;

  nalkc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .item_acc  (acc),
    .item_kind (in_tuser),
    .item_byte (in_tdata[7:0]),
    .item_last (in_tlast),
    .item_ckey (in_tdata[8]),
    .res_vld   (res_vld),
    .res       (res)
  );

  nalkc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (buf_full),
    .pop_vld   (out_tvalid),
    .pop_rdy   (out_tready),
    .pop_data  (out_res)
  );

  assign out_tdata = {1'b0, out_res};

endmodule : annexb_nal_keyframe_classifier

`default_nettype wire
